[design/pvs_pkg.sv]
package pvs_pkg;

  localparam int NUM_COEFS = 8;
  localparam int FRAC_BITS = 16;

  localparam int REG_COUNT = 8;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int NUM_STEPS = NUM_COEFS - 1;

  localparam logic signed [PROD_W-1:0] RND_HALF = (PROD_W'(1) << FRAC_BITS) >> 1;
  localparam logic signed [PROD_W-1:0] SAT_MAX  =
    {{(PROD_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_MIN  =
    {{(PROD_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     ovf;
  } sat_t;

  // one beat between horner steps
  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] slope;
    logic                     ovf;
  } item_t;

  // after the multiply half of a step
  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [PROD_W-1:0] pv;
    logic signed [PROD_W-1:0] ps;
    logic signed [DATA_W-1:0] slope;
    logic                     ovf;
  } prod_t;

  function automatic sat_t sat32(input logic signed [PROD_W-1:0] v);
    sat_t r;
    r.val = v[DATA_W-1:0];
    r.ovf = 1'b0;
    if (v > SAT_MAX) begin
      r.val = SAT_MAX[DATA_W-1:0];
      r.ovf = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val = SAT_MIN[DATA_W-1:0];
      r.ovf = 1'b1;
    end
    return r;
  endfunction

  // round half up, drop fraction bits, add coefficient, clamp
  function automatic sat_t round_add_sat(input logic signed [PROD_W-1:0] prod,
                                         input logic signed [DATA_W-1:0] c);
    logic signed [PROD_W-1:0] s;
    s = ((prod + RND_HALF) >>> FRAC_BITS) + PROD_W'(c);
    return sat32(s);
  endfunction

  // derivative coefficient deg * c
  function automatic sat_t deriv_coef(input logic signed [DATA_W-1:0] c,
                                      input logic [REG_IDX_W-1:0] deg);
    logic signed [DATA_W+REG_IDX_W:0] p;
    p = (DATA_W+REG_IDX_W+1)'(c) * (DATA_W+REG_IDX_W+1)'($signed({1'b0, deg}));
    return sat32(PROD_W'(p));
  endfunction

endpackage

[design/pvs_step.sv]
module pvs_step import pvs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  item_t                    in_item,
  input  logic signed [DATA_W-1:0] coef_v,
  input  logic signed [DATA_W-1:0] coef_s,
  input  logic                     slope_en,
  output logic                     out_valid,
  input  logic                     out_ready,
  output item_t                    out_item
);

  logic  a_vld;
  prod_t a;
  logic  b_vld;
  item_t b;
  logic  a_en;
  logic  b_en;
  sat_t  rv;
  sat_t  rs;

  assign b_en     = !b_vld || out_ready;
  assign a_en     = !a_vld || b_en;
  assign in_ready = a_en;

  // multiply half
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (a_en) begin
      a_vld <= in_valid;
    end
    if (a_en && in_valid) begin
      a.x     <= in_item.x;
      a.pv    <= PROD_W'(in_item.val) * PROD_W'(in_item.x);
      a.ps    <= PROD_W'(in_item.slope) * PROD_W'(in_item.x);
      a.slope <= in_item.slope;
      a.ovf   <= in_item.ovf;
    end
  end

  always_comb begin
    rv = round_add_sat(a.pv, coef_v);
    rs = round_add_sat(a.ps, coef_s);
  end

  // round, add and clamp half
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (b_en) begin
      b_vld <= a_vld;
    end
    if (b_en && a_vld) begin
      b.x     <= a.x;
      b.val   <= rv.val;
      b.slope <= slope_en ? rs.val : a.slope;
      b.ovf   <= a.ovf || rv.ovf || (slope_en && rs.ovf);
    end
  end

  assign out_valid = b_vld;
  assign out_item  = b;

endmodule

[design/poly_value_and_slope.sv]
// horner evaluation of p(x) and p'(x), one multiply-round-add step per coefficient below the top one
// throughput: one point per cycle while result_ready is held high; each step holds a multiply and a round-add stage
// stages advance independently, so bubbles close up behind a stalled result
// synchronous reset clears all valid bits and sets every coefficient to zero
module poly_value_and_slope import pvs_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        point_valid,
  output logic                        point_ready,
  input  logic signed [DATA_W-1:0]    point_x,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic signed [DATA_W-1:0]    poly_value,
  output logic signed [DATA_W-1:0]    slope_value,
  output logic                        overflow,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [REG_IDX_W-1:0]        cfg_index,
  input  logic [DATA_W-1:0]           cfg_data
);

  localparam logic [REG_IDX_W-1:0] REG_LAST = REG_IDX_W'(REG_COUNT - 1);
  localparam int TOP_IDX = REG_COUNT - NUM_COEFS;

  logic signed [DATA_W-1:0] coef  [REG_COUNT];
  logic signed [DATA_W-1:0] dcoef [REG_COUNT];
  logic [REG_COUNT-1:0]     dovf;
  sat_t                     dc_wr;
  logic                     dovf_any;

  logic  chain_vld  [NUM_STEPS+1];
  logic  chain_rdy  [NUM_STEPS+1];
  item_t chain_item [NUM_STEPS+1];

  assign cfg_ready = 1'b1;

  // derivative coefficient worked out when the register is written
  always_comb begin
    dc_wr = deriv_coef($signed(cfg_data), REG_LAST - cfg_index);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        coef[i]  <= '0;
        dcoef[i] <= '0;
      end
      dovf <= '0;
    end else if (cfg_valid && cfg_ready) begin
      coef[cfg_index]  <= $signed(cfg_data);
      dcoef[cfg_index] <= dc_wr.val;
      dovf[cfg_index]  <= dc_wr.ovf;
    end
  end

  // clamps in derivative coefficients of degree one and up count for every point
  always_comb begin
    dovf_any = 1'b0;
    for (int i = TOP_IDX; i < REG_COUNT - 1; i++) begin
      dovf_any = dovf_any | dovf[i];
    end
  end

  // the top coefficient starts both accumulators
  assign chain_vld[0]  = point_valid;
  assign chain_item[0] = {point_x, coef[TOP_IDX], dcoef[TOP_IDX], dovf_any};
  assign point_ready   = chain_rdy[0];

  for (genvar j = 0; j < NUM_STEPS; j++) begin : g_step
    localparam int DEG = NUM_STEPS - 1 - j;
    localparam int IDX = REG_COUNT - 1 - DEG;

    pvs_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_vld[j]),
      .in_ready  (chain_rdy[j]),
      .in_item   (chain_item[j]),
      .coef_v    (coef[IDX]),
      .coef_s    (dcoef[IDX]),
      .slope_en  (DEG != 0),
      .out_valid (chain_vld[j+1]),
      .out_ready (chain_rdy[j+1]),
      .out_item  (chain_item[j+1])
    );
  end

  assign chain_rdy[NUM_STEPS] = result_ready;
  assign result_valid         = chain_vld[NUM_STEPS];
  assign poly_value           = chain_item[NUM_STEPS].val;
  assign slope_value          = chain_item[NUM_STEPS].slope;
  assign overflow             = chain_item[NUM_STEPS].ovf;

endmodule
